// ----- rtl/mp2d_pkg.sv -----
package mp2d_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam int unsigned MAX_WINDOW    = 8;
  localparam int unsigned MAX_PLANES    = 1024;
  localparam int unsigned MAX_STEP      = 8;
  localparam int unsigned BANK_W        = 3;
  localparam int unsigned COL_W         = 12;
  localparam int unsigned CNT_W         = 11;
  localparam int unsigned SW            = 13;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 11;
  localparam int unsigned PIX_W         = 16;
  localparam int unsigned TAG_W         = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_PLANES = 3'd2,
    CFG_WINDOW = 3'd3,
    CFG_STEP   = 3'd4,
    CFG_PAD    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_REWIND,
    FR_WALK,
    FR_MARK
  } front_state_e;

  typedef enum logic {
    BK_FETCH,
    BK_CALC
  } back_state_e;

  typedef struct packed {
    logic                    marker;
    logic                    first;
    logic                    close;
    logic [BANK_W-1:0]       bank;
    logic [COL_W-1:0]        col;
    logic signed [PIX_W-1:0] value;
    logic [TAG_W-1:0]        chan;
    logic [TAG_W-1:0]        oy;
    logic [TAG_W-1:0]        ox;
  } task_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] value;
    logic [TAG_W-1:0]        chan;
    logic [TAG_W-1:0]        row;
    logic [TAG_W-1:0]        col;
    logic                    last;
  } result_t;

endpackage

// ----- rtl/mp2d_if.sv -----
interface mp2d_pix_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_value;
  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface mp2d_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pooled_value;
  logic [9:0]         out_channel;
  logic [9:0]         out_row;
  logic [9:0]         out_col;
  logic               run_last;
  modport source (output valid, output pooled_value, output out_channel, output out_row,
                  output out_col, output run_last, input ready);
  modport sink (input valid, input pooled_value, input out_channel, input out_row,
                input out_col, input run_last, output ready);
endinterface

interface mp2d_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [10:0] write_data;
  modport source (output valid, output reg_index, output write_data, input ready);
  modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

// ----- rtl/max_pool_2d_stream_unit.sv -----
// Streaming 2-D max pooling over signed 16-bit pixels in raster order, plane
// after plane. A front sequencer walks the window grid around each accepted
// pixel, one grid point per cycle while the task queue has room, and
// queues the windows that the pixel touches; a back engine does one
// read-modify-write of the running maximum per window, in a fetch and a
// calc state, and emits a result when a window closes, tagged with channel,
// output row and column, run_last set on the pixel's last one. Per pixel
// the front accepts it, steps the start points back, walks the window_size^2
// grid points and queues a marker; the back sets the rate when windows
// overlap heavily. The store holds 8 row banks of MAX_WIDTH entries
// and needs no clearing after reset. A register write restarts the tensor.
module max_pool_2d_stream_unit #(
  parameter int unsigned MAX_WIDTH = mp2d_pkg::DEF_MAX_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mp2d_cfg_if.sink         cfg_i,
  mp2d_pix_if.sink         pixel_i,
  mp2d_res_if.source       result_o
);
  import mp2d_pkg::*;

  localparam int unsigned AW = BANK_W + $clog2(MAX_WIDTH);

  task_t          push_task, head_task;
  result_t        res;
  logic           push, full, pop, empty;
  logic           re, we;
  logic [AW-1:0]  raddr, waddr;
  logic [PIX_W-1:0] rdata, wdata;

  assign cfg_i.ready = 1'b1;

  mp2d_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.reg_index),
    .cfg_data_i  (cfg_i.write_data),
    .pix_valid_i (pixel_i.valid),
    .pix_ready_o (pixel_i.ready),
    .pix_value_i (pixel_i.pixel_value),
    .push_o      (push),
    .task_o      (push_task),
    .full_i      (full)
  );

  mp2d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_task),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_task),
    .empty_o (empty)
  );

  mp2d_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .task_i      (head_task),
    .pop_o       (pop),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .res_valid_o (result_o.valid),
    .res_ready_i (result_o.ready),
    .res_o       (res)
  );

  mp2d_ram #(.WIDTH(PIX_W), .DEPTH((1 << BANK_W) * MAX_WIDTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign result_o.pooled_value = res.value;
  assign result_o.out_channel  = res.chan;
  assign result_o.out_row      = res.row;
  assign result_o.out_col      = res.col;
  assign result_o.run_last     = res.last;
endmodule

// ----- rtl/mp2d_ram.sv -----
module mp2d_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/mp2d_fifo.sv -----
module mp2d_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mp2d_pkg::task_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output mp2d_pkg::task_t data_o,
  output logic           empty_o
);
  import mp2d_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  task_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0]  wptr_q, rptr_q;
  logic [PW:0]    count_q;

  assign full_o  = (count_q == (PW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i) rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i) else $error("task queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("task queue underflow");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PW+1)'(QUEUE_DEPTH)) else $error("task queue count out of range");
`endif
endmodule

// ----- rtl/mp2d_front.sv -----
module mp2d_front #(
  parameter int unsigned MAX_WIDTH = mp2d_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              pix_valid_i,
  output logic                              pix_ready_o,
  input  logic signed [mp2d_pkg::PIX_W-1:0] pix_value_i,
  output logic                              push_o,
  output mp2d_pkg::task_t                   task_o,
  input  logic                              full_i
);
  import mp2d_pkg::*;

  logic [CNT_W-1:0] width_q, height_q, planes_q;
  logic [3:0]       window_q, step_q;
  logic [2:0]       pad_q;

  logic [CNT_W-1:0] w, h, np;
  logic [3:0]       sz, st;
  logic [2:0]       pd;

  always_comb begin
    w  = (width_q == '0) ? CNT_W'(1) : (width_q > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : width_q;
    h  = (height_q == '0) ? CNT_W'(1) : (height_q > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : height_q;
    np = (planes_q == '0) ? CNT_W'(1) : (planes_q > MAX_PLANES) ? CNT_W'(MAX_PLANES) : planes_q;
    sz = (window_q == '0) ? 4'd1 : (window_q > MAX_WINDOW) ? 4'(MAX_WINDOW) : window_q;
    st = (step_q == '0) ? 4'd1 : (step_q > MAX_STEP) ? 4'(MAX_STEP) : step_q;
    pd = ({1'b0, pad_q} > sz - 4'd1) ? 3'(sz - 4'd1) : pad_q;
  end

  front_state_e     state_q, state_d;
  logic [CNT_W-1:0] x_q, x_d, y_q, y_d, xq_q, xq_d, yq_q, yq_d, plane_q, plane_d;
  logic [3:0]       xr_q, xr_d, yr_q, yr_d;
  logic signed [PIX_W-1:0] v_q, v_d;
  logic [CNT_W-1:0] px_q, px_d, py_q, py_d, pc_q, pc_d;
  logic signed [SW-1:0] ri_q, ri_d, rq_q, rq_d, cj0_q, cj0_d, cq0_q, cq0_d;
  logic signed [SW-1:0] cj_q, cj_d, cq_q, cq_d;
  logic [3:0]       rr_q, rr_d, cr0_q, cr0_d, cr_q, cr_d;
  logic [2:0]       ti_q, ti_d, tj_q, tj_d, rew_q, rew_d;

  logic signed [SW-1:0] pd_s, sz_s, h_s, w_s, y_s, x_s;
  logic signed [SW-1:0] is_s, ie_s, js_s, je_s;
  logic row_ok, col_ok, hit, yfirst, xfirst, yclose, xclose;
  logic accept, cfg_hit;

  always_comb begin
    pd_s   = $signed(SW'(pd));
    sz_s   = $signed(SW'(sz));
    h_s    = $signed(SW'(h));
    w_s    = $signed(SW'(w));
    y_s    = $signed(SW'(py_q));
    x_s    = $signed(SW'(px_q));
    is_s   = ri_q - pd_s;
    ie_s   = is_s + sz_s - SW'(1);
    js_s   = cj_q - pd_s;
    je_s   = js_s + sz_s - SW'(1);
    row_ok = (ri_q >= 0) && (ri_q < h_s) && (rr_q == 4'd0);
    col_ok = (cj_q >= 0) && (cj_q < w_s) && (cr_q == 4'd0);
    hit    = row_ok && col_ok;
    yfirst = (y_s == ((is_s < 0) ? SW'(0) : is_s));
    xfirst = (x_s == ((js_s < 0) ? SW'(0) : js_s));
    yclose = (y_s == ((ie_s > h_s - SW'(1)) ? h_s - SW'(1) : ie_s));
    xclose = (x_s == ((je_s > w_s - SW'(1)) ? w_s - SW'(1) : je_s));
  end

  assign cfg_hit     = cfg_valid_i && (cfg_index_i <= CFG_PAD);
  assign pix_ready_o = (state_q == FR_IDLE);
  assign accept      = pix_valid_i && pix_ready_o;

  always_comb begin
    task_o        = '0;
    task_o.marker = (state_q == FR_MARK);
    task_o.first  = yfirst && xfirst;
    task_o.close  = yclose && xclose;
    task_o.bank   = rq_q[BANK_W-1:0];
    task_o.col    = cq_q[COL_W-1:0];
    task_o.value  = v_q;
    task_o.chan   = pc_q[TAG_W-1:0];
    task_o.oy     = rq_q[TAG_W-1:0];
    task_o.ox     = cq_q[TAG_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    x_d = x_q; y_d = y_q; xq_d = xq_q; yq_d = yq_q; xr_d = xr_q; yr_d = yr_q;
    plane_d = plane_q;
    v_d = v_q; px_d = px_q; py_d = py_q; pc_d = pc_q;
    ri_d = ri_q; rq_d = rq_q; rr_d = rr_q;
    cj0_d = cj0_q; cq0_d = cq0_q; cr0_d = cr0_q;
    cj_d = cj_q; cq_d = cq_q; cr_d = cr_q;
    ti_d = ti_q; tj_d = tj_q; rew_d = rew_q;
    push_o = 1'b0;

    unique case (state_q)
      FR_IDLE: begin
        if (accept) begin
          v_d   = pix_value_i;
          px_d  = x_q;
          py_d  = y_q;
          pc_d  = plane_q;
          ri_d  = $signed(SW'(y_q));
          rq_d  = $signed(SW'(yq_q));
          rr_d  = yr_q;
          cj0_d = $signed(SW'(x_q));
          cq0_d = $signed(SW'(xq_q));
          cr0_d = xr_q;
          rew_d = 3'(sz - 4'd1 - 4'(pd));
          ti_d  = '0;
          tj_d  = '0;
          state_d = FR_REWIND;
          // advance the raster position
          if (x_q + 1'b1 >= w) begin
            x_d = '0; xq_d = '0; xr_d = '0;
            if (y_q + 1'b1 >= h) begin
              y_d = '0; yq_d = '0; yr_d = '0;
              plane_d = (plane_q + 1'b1 >= np) ? '0 : plane_q + 1'b1;
            end else begin
              y_d = y_q + 1'b1;
              if (yr_q == st - 4'd1) begin
                yr_d = '0; yq_d = yq_q + 1'b1;
              end else begin
                yr_d = yr_q + 4'd1;
              end
            end
          end else begin
            x_d = x_q + 1'b1;
            if (xr_q == st - 4'd1) begin
              xr_d = '0; xq_d = xq_q + 1'b1;
            end else begin
              xr_d = xr_q + 4'd1;
            end
          end
        end
      end
      FR_REWIND: begin
        if (rew_q == '0) begin
          cj_d = cj0_q; cq_d = cq0_q; cr_d = cr0_q;
          state_d = FR_WALK;
        end else begin
          // step both start points back by one pixel
          rew_d = rew_q - 3'd1;
          ri_d  = ri_q - SW'(1);
          cj0_d = cj0_q - SW'(1);
          if (rr_q == 4'd0) begin
            rr_d = st - 4'd1; rq_d = rq_q - SW'(1);
          end else begin
            rr_d = rr_q - 4'd1;
          end
          if (cr0_q == 4'd0) begin
            cr0_d = st - 4'd1; cq0_d = cq0_q - SW'(1);
          end else begin
            cr0_d = cr0_q - 4'd1;
          end
        end
      end
      FR_WALK: begin
        if (!(hit && full_i)) begin
          push_o = hit;
          if (tj_q == 3'(sz - 4'd1)) begin
            tj_d = '0;
            cj_d = cj0_q; cq_d = cq0_q; cr_d = cr0_q;
            if (ti_q == 3'(sz - 4'd1)) begin
              state_d = FR_MARK;
            end else begin
              ti_d = ti_q + 3'd1;
              ri_d = ri_q + SW'(1);
              if (rr_q == st - 4'd1) begin
                rr_d = '0; rq_d = rq_q + SW'(1);
              end else begin
                rr_d = rr_q + 4'd1;
              end
            end
          end else begin
            tj_d = tj_q + 3'd1;
            cj_d = cj_q + SW'(1);
            if (cr_q == st - 4'd1) begin
              cr_d = '0; cq_d = cq_q + SW'(1);
            end else begin
              cr_d = cr_q + 4'd1;
            end
          end
        end
      end
      FR_MARK: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase

    // a register write starts a new tensor
    if (cfg_hit) begin
      x_d = '0; y_d = '0; xq_d = '0; yq_d = '0; xr_d = '0; yr_d = '0; plane_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CNT_W'(64);
      height_q <= CNT_W'(64);
      planes_q <= CNT_W'(1);
      window_q <= 4'd2;
      step_q   <= 4'd2;
      pad_q    <= 3'd0;
      state_q  <= FR_IDLE;
      x_q <= '0; y_q <= '0; xq_q <= '0; yq_q <= '0; xr_q <= '0; yr_q <= '0;
      plane_q <= '0;
      ti_q <= '0; tj_q <= '0; rew_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          CFG_PLANES: planes_q <= cfg_data_i;
          CFG_WINDOW: window_q <= cfg_data_i[3:0];
          CFG_STEP:   step_q   <= cfg_data_i[3:0];
          CFG_PAD:    pad_q    <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      state_q <= state_d;
      x_q <= x_d; y_q <= y_d; xq_q <= xq_d; yq_q <= yq_d; xr_q <= xr_d; yr_q <= yr_d;
      plane_q <= plane_d;
      ti_q <= ti_d; tj_q <= tj_d; rew_q <= rew_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; px_q <= px_d; py_q <= py_d; pc_q <= pc_d;
    ri_q <= ri_d; rq_q <= rq_d; rr_q <= rr_d;
    cj0_q <= cj0_d; cq0_q <= cq0_d; cr0_q <= cr0_d;
    cj_q <= cj_d; cq_q <= cq_d; cr_q <= cr_d;
  end
endmodule

// ----- rtl/mp2d_back.sv -----
module mp2d_back #(
  parameter int unsigned MAX_WIDTH = mp2d_pkg::DEF_MAX_WIDTH
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             empty_i,
  input  mp2d_pkg::task_t                                  task_i,
  output logic                                             pop_o,
  output logic                                             re_o,
  output logic [mp2d_pkg::BANK_W+$clog2(MAX_WIDTH)-1:0]    raddr_o,
  input  logic [mp2d_pkg::PIX_W-1:0]                       rdata_i,
  output logic                                             we_o,
  output logic [mp2d_pkg::BANK_W+$clog2(MAX_WIDTH)-1:0]    waddr_o,
  output logic [mp2d_pkg::PIX_W-1:0]                       wdata_o,
  output logic                                             res_valid_o,
  input  logic                                             res_ready_i,
  output mp2d_pkg::result_t                                res_o
);
  import mp2d_pkg::*;

  localparam int unsigned CAW = $clog2(MAX_WIDTH);

  back_state_e          state_q, state_d;
  task_t                t_q;
  result_t              held_q, held_d, out_q, out_d;
  logic                 held_v_q, held_v_d, out_v_q, out_v_d;
  logic                 out_free, go;
  logic signed [PIX_W-1:0] cur;

  assign out_free    = !out_v_q || res_ready_i;
  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  assign pop_o   = (state_q == BK_FETCH) && !empty_i;
  assign re_o    = pop_o && !task_i.marker;
  assign raddr_o = {task_i.bank, task_i.col[CAW-1:0]};
  assign waddr_o = {t_q.bank, t_q.col[CAW-1:0]};

  always_comb begin
    cur = (t_q.first || (t_q.value > $signed(rdata_i))) ? t_q.value : $signed(rdata_i);
  end
  assign wdata_o = cur;

  always_comb begin
    state_d  = state_q;
    held_d   = held_q;
    held_v_d = held_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q && !res_ready_i;
    we_o     = 1'b0;
    go       = 1'b0;
    unique case (state_q)
      BK_FETCH: begin
        if (pop_o) state_d = BK_CALC;
      end
      BK_CALC: begin
        if (t_q.marker) begin
          go = !held_v_q || out_free;
          if (go && held_v_q) begin
            // last closed window of this pixel
            out_d      = held_q;
            out_d.last = 1'b1;
            out_v_d    = 1'b1;
            held_v_d   = 1'b0;
          end
        end else begin
          go = !(t_q.close && held_v_q) || out_free;
          we_o = go;
          if (go && t_q.close) begin
            if (held_v_q) begin
              out_d   = held_q;
              out_v_d = 1'b1;
            end
            held_d.value = cur;
            held_d.chan  = t_q.chan;
            held_d.row   = t_q.oy;
            held_d.col   = t_q.ox;
            held_d.last  = 1'b0;
            held_v_d     = 1'b1;
          end
        end
        if (go) state_d = BK_FETCH;
      end
      default: state_d = BK_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_FETCH;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      held_v_q <= held_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) t_q <= task_i;
    held_q <= held_d;
    out_q  <= out_d;
  end
endmodule

// ----- test/mp2d_pool_checker.sv -----
module mp2d_pool_checker
  import mp2d_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  mp2d_cfg_if    cfg_mon,
  mp2d_pix_if    pix_mon,
  mp2d_res_if    res_mon,
  output int     fail_count_o,
  output int     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] value;
    logic [9:0]         chan;
    logic [9:0]         row;
    logic [9:0]         col;
    logic               last;
  } pooled_t;

  pooled_t            pooled_q[$];
  logic signed [15:0] win_max[MAX_WINDOW][DEF_MAX_WIDTH];
  logic [10:0]        img_w, img_h, n_planes;
  logic [3:0]         win_sz, step;
  logic [2:0]         pad;
  int                 col_pos, row_pos, plane_pos;
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = pooled_q.size();

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report(string what, int got, int exp_v);
    $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, exp_v);
    fails++;
  endtask

  // Update running maxima for one pixel and queue the windows it closes.
  task automatic pool_pixel(logic signed [15:0] v);
    int w, h, np, sz, st, pd, x, y, i, j, ys, ye, xs, xe, oy, ox;
    logic signed [15:0] cur;
    pooled_t closed[$];
    pooled_t r;
    w  = clamp(int'(img_w), 1, DEF_MAX_WIDTH);
    h  = clamp(int'(img_h), 1, DEF_MAX_WIDTH);
    np = clamp(int'(n_planes), 1, MAX_PLANES);
    sz = clamp(int'(win_sz), 1, MAX_WINDOW);
    st = clamp(int'(step), 1, MAX_STEP);
    pd = clamp(int'(pad), 0, sz - 1);
    x  = (col_pos >= w) ? w - 1 : col_pos;
    y  = (row_pos >= h) ? h - 1 : row_pos;
    for (int ti = sz - 1; ti >= 0; ti--) begin
      i = y + pd - ti;
      if (i < 0 || i >= h || (i % st) != 0) continue;
      ys = (i - pd < 0) ? 0 : i - pd;
      ye = (i - pd + sz - 1 > h - 1) ? h - 1 : i - pd + sz - 1;
      for (int tj = sz - 1; tj >= 0; tj--) begin
        j = x + pd - tj;
        if (j < 0 || j >= w || (j % st) != 0) continue;
        xs = (j - pd < 0) ? 0 : j - pd;
        xe = (j - pd + sz - 1 > w - 1) ? w - 1 : j - pd + sz - 1;
        oy = i / st;
        ox = j / st;
        if (y == ys && x == xs) cur = v;
        else begin
          cur = win_max[oy % MAX_WINDOW][ox];
          if (v > cur) cur = v;
        end
        win_max[oy % MAX_WINDOW][ox] = cur;
        if (y == ye && x == xe && closed.size() < 64) begin
          r.value = cur;
          r.chan  = plane_pos[9:0];
          r.row   = oy[9:0];
          r.col   = ox[9:0];
          r.last  = 1'b0;
          closed.push_back(r);
        end
      end
    end
    if (closed.size() > 0) closed[closed.size() - 1].last = 1'b1;
    foreach (closed[k]) pooled_q.push_back(closed[k]);
    // advance raster position
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) begin
        y = 0;
        plane_pos++;
        if (plane_pos >= np) plane_pos = 0;
      end
    end
    col_pos = x;
    row_pos = y;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pooled_t e;
    if (!rst_ni) begin
      img_w     = 11'd64;
      img_h     = 11'd64;
      n_planes  = 11'd1;
      win_sz    = 4'd2;
      step      = 4'd2;
      pad       = 3'd0;
      col_pos   = 0;
      row_pos   = 0;
      plane_pos = 0;
      fails     = 0;
      pooled_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready && (cfg_mon.reg_index <= CFG_PAD)) begin
        case (cfg_idx_e'(cfg_mon.reg_index))
          CFG_WIDTH:  img_w    = cfg_mon.write_data;
          CFG_HEIGHT: img_h    = cfg_mon.write_data;
          CFG_PLANES: n_planes = cfg_mon.write_data;
          CFG_WINDOW: win_sz   = cfg_mon.write_data[3:0];
          CFG_STEP:   step     = cfg_mon.write_data[3:0];
          CFG_PAD:    pad      = cfg_mon.write_data[2:0];
          default:    ;
        endcase
        col_pos   = 0;
        row_pos   = 0;
        plane_pos = 0;
      end
      if (pix_mon.valid && pix_mon.ready) pool_pixel(pix_mon.pixel_value);
      if (res_mon.valid && res_mon.ready) begin
        if (pooled_q.size() == 0) begin
          report("unexpected word", res_mon.pooled_value, 0);
        end else begin
          e = pooled_q.pop_front();
          if (res_mon.pooled_value !== e.value)
            report("pooled_value", res_mon.pooled_value, e.value);
          if (res_mon.out_channel !== e.chan)
            report("out_channel", res_mon.out_channel, e.chan);
          if (res_mon.out_row !== e.row) report("out_row", res_mon.out_row, e.row);
          if (res_mon.out_col !== e.col) report("out_col", res_mon.out_col, e.col);
          if (res_mon.run_last !== e.last) report("run_last", res_mon.run_last, e.last);
        end
      end
    end
  end

endmodule

// ----- test/tb_max_pool_2d_stream_unit.sv -----
module tb_max_pool_2d_stream_unit;
  import mp2d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN      = 200;

  logic clk_i;
  logic rst_ni;
  int   fail_count, pending;
  int   gap_pct, stall_pct, sent, idle_cycles;

  mp2d_cfg_if cfg();
  mp2d_pix_if pix();
  mp2d_res_if res();

  max_pool_2d_stream_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .pixel_i (pix),
    .result_o(res)
  );

  mp2d_pool_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_mon     (cfg),
    .pix_mon     (pix),
    .res_mon     (res),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) res.ready <= ($urandom_range(99) >= stall_pct);

  // Watchdog: count cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((cfg.valid && cfg.ready) || (pix.valid && pix.ready) || (res.valid && res.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Hold off until all pooled words are back, then let in-flight pixels settle.
  task automatic wait_drained();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [10:0] data);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.write_data <= data;
    do @(posedge clk_i); while (!cfg.ready);
  endtask

  task automatic setup(int w, int h, int np, int sz, int st, int pd);
    wait_drained();
    write_reg(CFG_WIDTH, w[10:0]);
    write_reg(CFG_HEIGHT, h[10:0]);
    write_reg(CFG_PLANES, np[10:0]);
    write_reg(CFG_WINDOW, sz[10:0]);
    write_reg(CFG_STEP, st[10:0]);
    write_reg(CFG_PAD, pd[10:0]);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_pixel(logic signed [15:0] v);
    // idle mode follows overall progress
    if (sent < 60) begin
      gap_pct = 28; stall_pct = 62;
    end else if (sent < 120) begin
      gap_pct = 62; stall_pct = 28;
    end else begin
      gap_pct = 0; stall_pct = 0;
    end
    while ($urandom_range(99) < gap_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid       <= 1'b1;
    pix.pixel_value <= v;
    do @(posedge clk_i); while (!pix.ready);
    sent++;
  endtask

  initial begin
    logic signed [15:0] edge_vals[5];
    int w, h, np, count;
    edge_vals = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001};
    rst_ni          = 1'b0;
    cfg.valid       = 1'b0;
    cfg.reg_index   = CFG_WIDTH;
    cfg.write_data  = '0;
    pix.valid       = 1'b0;
    pix.pixel_value = '0;
    res.ready       = 1'b0;
    sent            = 0;
    idle_cycles     = 0;
    gap_pct         = 28;
    stall_pct       = 62;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // overlapping windows with border clipping across two planes
    setup(3, 3, 2, 2, 1, 1);
    for (int k = 0; k < 18; k++)
      send_pixel(k < 5 ? edge_vals[k] : 16'($urandom));
    // out-of-range registers: width 1, one pixel windows, pad held to zero
    setup(0, 1, 2047, 0, 0, 7);
    for (int k = 0; k < 3; k++) send_pixel(16'($urandom));
    // largest image, 8 by 8 window, step 8, pad 7
    setup(2047, 2047, 0, 15, 15, 7);
    for (int k = 0; k < 4; k++) send_pixel(16'($urandom));

    count = 0;
    while (count < 135) begin
      w  = $urandom_range(1, 8);
      h  = $urandom_range(1, 5);
      np = $urandom_range(1, 2);
      setup(w, h, np, $urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 7));
      for (int k = 0; k < w * h * np; k++) send_pixel(16'($urandom));
      count += w * h * np;
    end

    wait_drained();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mp2d_pkg.sv
rtl/mp2d_if.sv
rtl/mp2d_ram.sv
rtl/mp2d_fifo.sv
rtl/mp2d_front.sv
rtl/mp2d_back.sv
rtl/max_pool_2d_stream_unit.sv
test/mp2d_pool_checker.sv
test/tb_max_pool_2d_stream_unit.sv
